>>> rtl/csrmv_pkg.sv
`default_nettype none

package csrmv_pkg;

    // Field widths of the stream items
    localparam int IDX_W    = 10;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 11;
    localparam int STAT_W   = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Running row sum is bounded to +-2^56, so 58 signed bits hold it
    localparam int ACC_W  = 58;
    localparam int PROD_W = 64;
    localparam int TERM_W = 48;

    // Result queue behind the pipeline
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    localparam logic [LEN_W-1:0] VEC_LEN_RESET = 11'd1024;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_NZ    = 2'd1,
        MODE_EMPTY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_SAT   = 2'd2
    } t_status;

    // One finished row, row_index in the low bits
    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  row_sum;
        logic [IDX_W-1:0]  row_index;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/csrmv_ram.sv
`default_nettype none

module csrmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/csr_sparse_matvec.sv
`default_nettype none
// Sparse matrix times dense vector, matrix streamed in CSR order.
// Slave stream: tuser = mode (0 load element, 1 nonzero, 2 empty row),
// tdata = column/element index and Q16.16 value, tlast = last nonzero of row.
// Load items write the vector store; nonzeros multiply the stored element and
// accumulate; a closing item (nonzero with tlast, or empty row) emits a result.
// Master stream: tdata = row index, saturated Q16.16 row sum, status.
// Config channel writes vector_length (columns allowed); the user must write it
// only while idle, as the block does not enforce it. Throughput: one item per
// clock while o_s_tready is high; each item takes one vector store read, one
// 32x32 multiply and one accumulate. A closing item passes the stage 1 to 3
// registers into an 8-entry result queue that decouples the sides; o_s_tready
// drops only when the queue plus closing items in flight would fill it, so a
// stalled receiver backs up into the input without losing results.
// Reset clears the pipeline, queue, accumulator, row counter and error flag
// and sets vector_length to 1024. The vector store is not cleared: elements
// must be loaded before they are used.
module csr_sparse_matvec
    import csrmv_pkg::*;
#(
    parameter int MAX_DIM = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // slave stream
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // [9:0] index, [41:10] value
    input  wire logic [1:0]             i_s_tuser,   // [1:0] mode
    input  wire logic                   i_s_tlast,   // row_end
    // master stream
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // [9:0] row_index, [41:10] row_sum,
                                                     // [43:42] status
    // configuration
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [LEN_W-1:0]       i_cfg_data
);

    localparam int AW = $clog2(MAX_DIM);
    localparam logic [16:0] MAX_DIM_W = 17'(MAX_DIM);

    // Configuration register
    logic [LEN_W-1:0] r_vec_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len <= VEC_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vec_len <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Input decode
    logic              s_acc;
    t_mode             in_mode;
    logic [IDX_W-1:0]  in_idx;
    logic [VAL_W-1:0]  in_val;
    logic [16:0]       in_idx_ext;
    logic [AW-1:0]     in_addr;
    logic              in_range;
    logic              in_nz;
    logic              in_close;
    logic              in_we;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign in_mode    = t_mode'(i_s_tuser);
    assign in_idx     = i_s_tdata[IDX_W-1:0];
    assign in_val     = i_s_tdata[IDX_W+VAL_W-1:IDX_W];
    assign in_idx_ext = {7'd0, in_idx};
    assign in_addr    = in_idx_ext[AW-1:0];
    assign in_range   = ({1'b0, in_idx} < r_vec_len) && (in_idx_ext < MAX_DIM_W);

    always_comb begin
        in_we    = 1'b0;
        in_nz    = 1'b0;
        in_close = 1'b0;
        case (in_mode)
            MODE_LOAD: begin
                in_we = in_range;
            end
            MODE_NZ: begin
                in_nz    = 1'b1;
                in_close = i_s_tlast;
            end
            MODE_EMPTY: begin
                in_close = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Vector store, read at the accept edge so data lines up with stage 1
    logic [VAL_W-1:0] ram_rdata;

    csrmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_DIM)
    ) u_vec_store (
        .i_clk   (i_clk),
        .i_we    (s_acc && in_we),
        .i_waddr (in_addr),
        .i_wdata (in_val),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // Stage 1: item registered next to the store read data
    logic             r_s1_vld, r_s1_mac, r_s1_err, r_s1_close;
    logic [VAL_W-1:0] r_s1_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= s_acc && (in_nz || in_close);
        end
        r_s1_mac   <= in_nz && in_range;
        r_s1_err   <= in_nz && !in_range;
        r_s1_close <= in_close;
        r_s1_val   <= in_val;
    end

    // Stage 2: product
    logic                     r_s2_vld, r_s2_mac, r_s2_err, r_s2_close;
    logic signed [PROD_W-1:0] r_s2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_mac   <= r_s1_mac;
        r_s2_err   <= r_s1_err;
        r_s2_close <= r_s1_close;
        r_s2_prod  <= $signed(r_s1_val) * $signed(ram_rdata);
    end

    // Stage 3: round to Q16.16, accumulate with saturation at +-2^56
    localparam logic signed [ACC_W:0] ACC_MAX = 59'sd1 <<< 56;
    localparam logic signed [ACC_W:0] ACC_MIN = -(59'sd1 <<< 56);

    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_err_flag;
    logic [IDX_W-1:0]         r_row_cnt;

    logic signed [PROD_W-1:0] s3_rnd;
    logic signed [TERM_W-1:0] s3_term;
    logic signed [ACC_W:0]    s3_sum;
    logic signed [ACC_W-1:0]  s3_sat;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     n_err;

    always_comb begin
        s3_rnd  = r_s2_prod + 64'sd32768;
        s3_term = s3_rnd[PROD_W-1:16];
        s3_sum  = {r_acc[ACC_W-1], r_acc} + {{(ACC_W+1-TERM_W){s3_term[TERM_W-1]}}, s3_term};
        if (s3_sum > ACC_MAX) begin
            s3_sat = ACC_MAX[ACC_W-1:0];
        end else if (s3_sum < ACC_MIN) begin
            s3_sat = ACC_MIN[ACC_W-1:0];
        end else begin
            s3_sat = s3_sum[ACC_W-1:0];
        end
        n_acc = r_s2_mac ? s3_sat : r_acc;
        n_err = r_err_flag || r_s2_err;
    end

    logic                    r_s4_vld;
    logic signed [ACC_W-1:0] r_s4_sum;
    logic                    r_s4_err;
    logic [IDX_W-1:0]        r_s4_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_err_flag <= 1'b0;
            r_row_cnt  <= '0;
            r_s4_vld   <= 1'b0;
        end else begin
            r_s4_vld <= r_s2_vld && r_s2_close;
            if (r_s2_vld) begin
                if (r_s2_close) begin
                    r_acc      <= '0;
                    r_err_flag <= 1'b0;
                    r_row_cnt  <= r_row_cnt + 1'b1;
                end else begin
                    r_acc      <= n_acc;
                    r_err_flag <= n_err;
                end
            end
        end
        r_s4_sum <= n_acc;
        r_s4_err <= n_err;
        r_s4_row <= r_row_cnt;
    end

    // Stage 4: clamp to 32 bits and pick status
    t_result s4_res;

    always_comb begin
        s4_res.row_index = r_s4_row;
        s4_res.status    = STATUS_OK;
        if (r_s4_sum > ACC_W'(64'sh7FFF_FFFF)) begin
            s4_res.row_sum = 32'h7FFF_FFFF;
            s4_res.status  = STATUS_SAT;
        end else if (r_s4_sum < -ACC_W'(64'sh8000_0000)) begin
            s4_res.row_sum = 32'h8000_0000;
            s4_res.status  = STATUS_SAT;
        end else begin
            s4_res.row_sum = r_s4_sum[VAL_W-1:0];
        end
        if (r_s4_err) begin
            s4_res.status = STATUS_RANGE;
        end
    end

    // Result queue
    t_result             r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]  r_fifo_cnt;
    logic                fifo_push, fifo_pop;

    assign fifo_push = r_s4_vld;
    assign fifo_pop  = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (fifo_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (fifo_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({fifo_push, fifo_pop})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + 1'b1;
                2'b01:   r_fifo_cnt <= r_fifo_cnt - 1'b1;
                default: r_fifo_cnt <= r_fifo_cnt;
            endcase
        end
        if (fifo_push) begin
            r_fifo[r_wr_ptr] <= s4_res;
        end
    end

    assign o_m_tvalid = (r_fifo_cnt != '0);
    assign o_m_tdata  = {(OUT_TDATA_W-$bits(t_result))'(0), r_fifo[r_rd_ptr]};

    // Credit: closing items still in the pipeline each hold a queue slot
    logic [2:0]         inflight;
    logic [FIFO_CW:0]   credit_used;

    assign inflight = 3'(r_s1_vld && r_s1_close) + 3'(r_s2_vld && r_s2_close)
                    + 3'(r_s4_vld);
    assign credit_used = {1'b0, r_fifo_cnt} + (FIFO_CW+1)'(inflight);
    assign o_s_tready  = (credit_used < (FIFO_CW+1)'(FIFO_DEPTH));

`ifndef SYNTHESIS
    // Queue never takes a result while full, unless one leaves in the same cycle
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_push |-> (r_fifo_cnt < FIFO_CW'(FIFO_DEPTH)) || fifo_pop)
        else $error("result queue overflow");

    // Reserved slots never exceed the queue depth
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        credit_used <= (FIFO_CW+1)'(FIFO_DEPTH))
        else $error("credit count exceeds queue depth");

    // Closing a row clears the accumulator and error flag
    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_close) |=> (r_acc == '0) && !r_err_flag)
        else $error("row state not cleared after close");

    // Each closed row advances the row counter by one
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_close) |=> (r_row_cnt == $past(r_row_cnt) + 1'b1))
        else $error("row counter did not advance");
`endif

endmodule

`default_nettype wire

>>> bench/csr_sparse_matvec_test.sv
`timescale 1ns / 1ps

module csr_sparse_matvec_test;
    import csrmv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam longint ACC_CAP = 64'sd1 << 56;

    typedef enum logic {STEP_ITEM, STEP_CFG} t_step_kind;

    // one line of the directed plan: a stream item or a length write
    typedef struct {
        t_step_kind        kind;
        t_mode             mode;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  val;
        logic              last;
        bit                typed;
        t_result           want;
        logic [LEN_W-1:0]  len;
    } t_plan_step;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata = '0;     // [9:0] index, [41:10] value
    logic [1:0]              i_s_tuser = '0;     // [1:0] mode
    logic                    i_s_tlast = 1'b0;   // row_end
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;          // [9:0] row_index, [41:10] row_sum,
                                                 // [43:42] status
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [LEN_W-1:0]        i_cfg_data = '0;

    // shadow of the block's state
    logic [VAL_W-1:0]   vec_mem [1024];
    bit                 vec_written [1024];
    logic [IDX_W-1:0]   written_cols [$];
    longint             row_acc = 0;
    logic [IDX_W-1:0]   row_ctr = '0;
    bit                 row_bad = 1'b0;
    bit                 row_open = 1'b0;
    logic [LEN_W-1:0]   vec_len = VEC_LEN_RESET;

    t_result     pending_rows [$];
    t_plan_step  plan [$];

    bit   sender_gaps = 1'b1;
    bit   sink_stalls = 1'b1;
    int   stall_left = 0;
    int   mismatches = 0;
    int   items_sent = 0;
    int   rows_seen = 0;
    int   cfg_writes = 0;
    int   cycle_count = 0;

    csr_sparse_matvec dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still pending",
                     cycle_count, pending_rows.size());
            $display("csr_sparse_matvec_test failed");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 40)
            $display("MISMATCH row %0d %s: got %0h want %0h", rows_seen, what, got, want);
        mismatches++;
    endtask

    // closes the current row and returns its result
    function automatic t_result finish_row();
        t_result r;
        longint s;
        s = row_acc;
        r.status = STATUS_OK;
        if (s > 64'sd2147483647) begin
            s = 64'sd2147483647;
            r.status = STATUS_SAT;
        end else if (s < -64'sd2147483648) begin
            s = -64'sd2147483648;
            r.status = STATUS_SAT;
        end
        if (row_bad)
            r.status = STATUS_RANGE;
        r.row_index = row_ctr;
        r.row_sum = s[31:0];
        row_ctr = row_ctr + 1'b1;
        row_acc = 0;
        row_bad = 1'b0;
        row_open = 1'b0;
        return r;
    endfunction

    // applies one accepted item to the shadow state; returns 1 when a row closes
    function automatic bit advance_matvec(t_mode mode, logic [IDX_W-1:0] idx,
                                          logic [VAL_W-1:0] val, logic last,
                                          output t_result res);
        longint prod;
        longint term;
        bit hit;
        hit = ({1'b0, idx} < vec_len);
        res = '0;
        case (mode)
            MODE_LOAD: begin
                if (hit) begin
                    vec_mem[idx] = val;
                    if (!vec_written[idx]) begin
                        vec_written[idx] = 1'b1;
                        written_cols.push_back(idx);
                    end
                end
                return 1'b0;
            end
            MODE_EMPTY: begin
                res = finish_row();
                return 1'b1;
            end
            MODE_NZ: begin
                if (hit) begin
                    prod = longint'($signed(val)) * longint'($signed(vec_mem[idx]));
                    // round half up to Q16.16
                    term = (prod + 64'sd32768) >>> 16;
                    row_acc = row_acc + term;
                    if (row_acc > ACC_CAP)
                        row_acc = ACC_CAP;
                    else if (row_acc < -ACC_CAP)
                        row_acc = -ACC_CAP;
                end else begin
                    row_bad = 1'b1;
                end
                row_open = 1'b1;
                if (last) begin
                    res = finish_row();
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // offer one item, wait for its transaction, record the expected row
    task automatic stream_entry(t_mode mode, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                                logic last, bit typed, t_result want);
        t_result predicted;
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {6'b0, val, idx};
        i_s_tuser <= mode;
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        if (advance_matvec(mode, idx, val, last, predicted))
            pending_rows.push_back(typed ? want : predicted);
    endtask

    // hold the input until every expected row is out and the pipeline is empty
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_len(logic [LEN_W-1:0] len);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        vec_len = len;
        cfg_writes++;
    endtask

    function automatic logic [VAL_W-1:0] q16_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFFFFFF;
                    1: v = 32'h80000000;
                    2: v = 32'h0;
                    default: v = 32'hFFFFFFFF;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(8, 24);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // one random item, mostly well-formed rows over loaded columns
    task automatic random_item();
        int pick;
        int eff_len;
        logic [IDX_W-1:0] idx;
        bit found;
        t_mode mode;
        logic last;
        pick = $urandom_range(0, 99);
        eff_len = (vec_len > 1024) ? 1024 : int'(vec_len);
        last = 1'($urandom_range(0, 1));
        idx = 10'($urandom_range(0, 1023));
        mode = MODE_NZ;
        if (pick < 14) begin
            mode = MODE_LOAD;
            if (eff_len > 0 && $urandom_range(0, 9) != 0)
                idx = 10'($urandom_range(0, eff_len - 1));
        end else if (pick < 84) begin
            found = 1'b0;
            last = ($urandom_range(0, 2) == 0);
            if (!(eff_len < 1024 && $urandom_range(0, 11) == 0)) begin
                for (int t = 0; t < 8 && !found && written_cols.size() != 0; t++) begin
                    idx = written_cols[$urandom_range(0, written_cols.size() - 1)];
                    found = (int'(idx) < eff_len);
                end
            end
            // never read an element that was not loaded
            if (!found) begin
                if (eff_len < 1024) begin
                    idx = 10'($urandom_range(eff_len, 1023));
                end else begin
                    mode = MODE_LOAD;
                    idx = 10'($urandom_range(0, 1023));
                end
            end
        end else if (pick < 96) begin
            mode = MODE_EMPTY;
        end else begin
            mode = MODE_NONE;
        end
        stream_entry(mode, idx, q16_value(), last, 1'b0, '0);
    endtask

    task automatic run_phase(logic [LEN_W-1:0] len, int n_items, bit gaps, bit stalls);
        sender_gaps = gaps;
        sink_stalls = stalls;
        write_len(len);
        for (int k = 0; k < n_items; k++) begin
            random_item();
            // sender holds off until the result side has fully caught up
            if (k == n_items / 2 && !gaps && stalls)
                wait_idle();
        end
        if (row_open)
            stream_entry(MODE_EMPTY, 10'($urandom), $urandom, 1'($urandom), 1'b0, '0);
    endtask

    function automatic t_plan_step item_row(t_mode mode, logic [IDX_W-1:0] idx,
                                            logic [VAL_W-1:0] val, logic last);
        t_plan_step s;
        s = '{kind: STEP_ITEM, mode: mode, idx: idx, val: val, last: last,
              typed: 1'b0, want: '0, len: '0};
        return s;
    endfunction

    function automatic t_plan_step typed_row(t_mode mode, logic [IDX_W-1:0] idx,
                                             logic [VAL_W-1:0] val, logic last,
                                             logic [IDX_W-1:0] ridx, logic [VAL_W-1:0] sum,
                                             t_status st);
        t_plan_step s;
        s = item_row(mode, idx, val, last);
        s.typed = 1'b1;
        s.want.row_index = ridx;
        s.want.row_sum = sum;
        s.want.status = st;
        return s;
    endfunction

    function automatic t_plan_step cfg_row(logic [LEN_W-1:0] len);
        t_plan_step s;
        s = item_row(MODE_NONE, '0, '0, 1'b0);
        s.kind = STEP_CFG;
        s.len = len;
        return s;
    endfunction

    // result side: random stall bursts, compare each transaction with the oldest row
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_rows.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[31:0], '0);
            end else begin
                if (o_m_tdata[9:0] != pending_rows[0].row_index)
                    report_mismatch("row_index", 32'(o_m_tdata[9:0]),
                                    32'(pending_rows[0].row_index));
                if (o_m_tdata[41:10] != pending_rows[0].row_sum)
                    report_mismatch("row_sum", o_m_tdata[41:10], pending_rows[0].row_sum);
                if (o_m_tdata[43:42] != pending_rows[0].status)
                    report_mismatch("status", 32'(o_m_tdata[43:42]),
                                    32'(pending_rows[0].status));
                if (o_m_tdata[47:44] != '0)
                    report_mismatch("padding", 32'(o_m_tdata[47:44]), '0);
                void'(pending_rows.pop_front());
            end
            rows_seen++;
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 11);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    initial begin
        // directed plan, rows numbered from reset
        plan.push_back(typed_row(MODE_EMPTY, 10'd0, 32'h0, 1'b0, 10'd0, 32'h0, STATUS_OK));
        plan.push_back(item_row(MODE_LOAD, 10'd0, 32'h00010000, 1'b0));
        plan.push_back(item_row(MODE_LOAD, 10'd1023, 32'h7FFFFFFF, 1'b0));
        plan.push_back(item_row(MODE_LOAD, 10'd1, 32'h80000000, 1'b0));
        plan.push_back(item_row(MODE_LOAD, 10'd2, 32'hFFFF0000, 1'b0));
        plan.push_back(item_row(MODE_LOAD, 10'd682, 32'h55555555, 1'b1));
        plan.push_back(item_row(MODE_LOAD, 10'd341, 32'hAAAAAAAA, 1'b0));
        plan.push_back(typed_row(MODE_NZ, 10'd0, 32'h00020000, 1'b1,
                                 10'd1, 32'h00020000, STATUS_OK));
        // max times max and max times min both clip
        plan.push_back(typed_row(MODE_NZ, 10'd1023, 32'h7FFFFFFF, 1'b1,
                                 10'd2, 32'h7FFFFFFF, STATUS_SAT));
        plan.push_back(typed_row(MODE_NZ, 10'd1, 32'h7FFFFFFF, 1'b1,
                                 10'd3, 32'h80000000, STATUS_SAT));
        // unused mode does nothing
        plan.push_back(item_row(MODE_NONE, 10'd1023, 32'hFFFFFFFF, 1'b1));
        // empty-row item closes a partly built row
        plan.push_back(item_row(MODE_NZ, 10'd2, 32'h00010000, 1'b0));
        plan.push_back(item_row(MODE_NZ, 10'd0, 32'h00030000, 1'b0));
        plan.push_back(typed_row(MODE_EMPTY, 10'd0, 32'h0, 1'b0,
                                 10'd4, 32'h00020000, STATUS_OK));
        // rounding of tiny products
        plan.push_back(item_row(MODE_NZ, 10'd682, 32'h00000001, 1'b1));
        plan.push_back(item_row(MODE_NZ, 10'd0, 32'hFFFFFFFF, 1'b1));
        // one column allowed: loads past it are dropped, bad column wins over clipping
        plan.push_back(cfg_row(11'd1));
        plan.push_back(item_row(MODE_LOAD, 10'd1, 32'h12345678, 1'b0));
        plan.push_back(typed_row(MODE_NZ, 10'd1, 32'h00010000, 1'b1,
                                 10'd7, 32'h0, STATUS_RANGE));
        plan.push_back(item_row(MODE_NZ, 10'd0, 32'h7FFFFFFF, 1'b0));
        plan.push_back(item_row(MODE_NZ, 10'd0, 32'h7FFFFFFF, 1'b0));
        plan.push_back(typed_row(MODE_NZ, 10'd5, 32'h00000001, 1'b1,
                                 10'd8, 32'h7FFFFFFF, STATUS_RANGE));
        // zero length: every column is bad
        plan.push_back(cfg_row(11'd0));
        plan.push_back(typed_row(MODE_NZ, 10'd0, 32'h00010000, 1'b1,
                                 10'd9, 32'h0, STATUS_RANGE));
        plan.push_back(item_row(MODE_LOAD, 10'd0, 32'h00000005, 1'b0));
        // length above the store size acts as full size
        plan.push_back(cfg_row(11'd2047));
        plan.push_back(typed_row(MODE_NZ, 10'd1023, 32'h00010000, 1'b1,
                                 10'd10, 32'h7FFFFFFF, STATUS_OK));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].kind == STEP_CFG)
                write_len(plan[n].len);
            else
                stream_entry(plan[n].mode, plan[n].idx, plan[n].val, plan[n].last,
                             plan[n].typed, plan[n].want);
        end

        // random phases over a range of lengths, with and without idling
        run_phase(11'd1024, 50, 1'b1, 1'b1);
        run_phase(11'd1024, 60, 1'b1, 1'b1);
        run_phase(11'd1, 60, 1'b1, 1'b1);
        run_phase(11'($urandom_range(2, 1023)), 120, 1'b0, 1'b1);
        run_phase(11'd0, 25, 1'b1, 1'b0);
        run_phase(11'd2047, 100, 1'b0, 1'b1);
        run_phase(11'($urandom_range(1, 1024)), 100, 1'b1, 1'b1);
        run_phase(11'd1024, 100, 1'b0, 1'b0);

        wait_idle();
        $display("covered %0d input transactions, %0d row results, %0d length writes",
                 items_sent, rows_seen, cfg_writes);
        $display("lengths 0, 1, random, full and oversize; idle bursts on both sides, then none");
        if (mismatches == 0) begin
            $display("csr_sparse_matvec_test passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("csr_sparse_matvec_test failed");
        end
        $finish;
    end

endmodule
